/* hw/rtl/fspc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fspc_pkg
// Widths, codes and reset values shared by the fiber shell point classifier.
// ----------------------------------------------------------------------------
package fspc_pkg;

    // item field widths
    localparam int POS_W   = 24;
    localparam int DIR_W   = 16;
    localparam int RAD_W   = 23;
    localparam int SHELL_W = 2;
    localparam int FIB_W   = 2;

    // arithmetic widths
    localparam int FRAC_W  = 15;                    // direction fraction bits
    localparam int PROD_W  = POS_W + DIR_W;         // p * d
    localparam int PROJ_W  = PROD_W + 1;            // sum of three products
    localparam int MUL2_W  = PROJ_W + DIR_W;        // proj * d
    localparam int OFF_W   = MUL2_W + 1;            // offset before rounding, Q.30
    localparam int RND_SH  = 2 * FRAC_W;            // 30
    localparam int RND_W   = OFF_W - RND_SH;        // rounded offset, whole nm
    localparam int SQ_W    = 2 * RND_W;             // signed square, never negative
    localparam int DS_W    = SQ_W + 1;              // sum of three squares
    localparam int R2_W    = 2 * RAD_W;             // squared radius

    // pipeline depth
    localparam int NSTG    = 7;

    // configuration
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RAD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_A_X  = 3'd0,
        CFG_DIR_A_Y  = 3'd1,
        CFG_DIR_A_Z  = 3'd2,
        CFG_DIR_B_X  = 3'd3,
        CFG_DIR_B_Y  = 3'd4,
        CFG_DIR_B_Z  = 3'd5,
        CFG_INNER    = 3'd6,
        CFG_OUTER    = 3'd7
    } t_cfg_idx;

    localparam logic signed [DIR_W-1:0] DIR_A_X_RST = 16'sd23170;
    localparam logic signed [DIR_W-1:0] DIR_A_Y_RST = 16'sd23170;
    localparam logic signed [DIR_W-1:0] DIR_A_Z_RST = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_B_X_RST = 16'sd23170;
    localparam logic signed [DIR_W-1:0] DIR_B_Y_RST = -16'sd23170;
    localparam logic signed [DIR_W-1:0] DIR_B_Z_RST = 16'sd0;
    localparam logic [RAD_W-1:0]        RADIUS_RST  = 23'd2000000;

    // point modes
    localparam logic MODE_KISS  = 1'b0;
    localparam logic MODE_CROSS = 1'b1;

    // result codes
    typedef enum logic [SHELL_W-1:0] {
        SHELL_CORE   = 2'd0,
        SHELL_SHEATH = 2'd1,
        SHELL_OUT    = 2'd2
    } t_shell;

    localparam logic signed [FIB_W-1:0] FIB_0    = 2'sd0;
    localparam logic signed [FIB_W-1:0] FIB_1    = 2'sd1;
    localparam logic signed [FIB_W-1:0] FIB_NONE = -2'sd1;

    // per-item control that travels with the data
    typedef struct packed {
        logic                    mode;   // 0 kissing, 1 crossing
        logic signed [FIB_W-1:0] hint;
        logic                    x_neg;
    } t_ctl;

endpackage
`default_nettype wire

/* hw/rtl/fspc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fspc_in_if
// Point channel: valid/ready handshake with coordinates, mode and hint.
// ----------------------------------------------------------------------------
interface fspc_in_if import fspc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    mode;
    logic signed [FIB_W-1:0] hint_fiber;

    modport source (
        output valid, pos_x, pos_y, pos_z, mode, hint_fiber,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, mode, hint_fiber,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/fspc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fspc_out_if
// Classification channel: valid/ready handshake with shell and fiber id.
// ----------------------------------------------------------------------------
interface fspc_out_if import fspc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [SHELL_W-1:0]      shell;
    logic signed [FIB_W-1:0] fiber_id;

    modport source (
        output valid, shell, fiber_id,
        input  ready
    );
    modport sink (
        input  valid, shell, fiber_id,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/fiber_shell_point_classifier.sv */
`default_nettype none
// An accepted point passes through seven registered stages to the output register.
// Throughput: one item per cycle unless the output stalls; a seven-stage
// multiply/round/square pipeline with a valid bit per stage, and a stage with a
// bubble loads even while the output is stalled.
// Reset: clears all stage valid bits and loads the default fiber directions
// and radii; the derived squared radii are not reset but registered from them.
// ----------------------------------------------------------------------------
// fiber_shell_point_classifier
// Classifies a 3-D point against two fibers through the origin by squared
// perpendicular distance against squared core and sheath radii.
// ----------------------------------------------------------------------------
module fiber_shell_point_classifier import fspc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    fspc_in_if.sink                    i_pt,
    fspc_out_if.source                 o_cls
);

    // configuration registers
    logic signed [DIR_W-1:0] r_dir [2][3];
    logic [RAD_W-1:0]        r_inner;
    logic [RAD_W-1:0]        r_outer;
    logic [RAD_W-1:0]        r_rm;
    logic [R2_W-1:0]         r_ra2;
    logic [R2_W-1:0]         r_rm2;

    // pipeline valid bits and per-stage advance
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    t_ctl            r_ctl [NSTG-1];

    // stage data
    logic signed [POS_W-1:0]  r_pos1 [3];
    logic signed [POS_W-1:0]  r_pos2 [3];
    logic signed [POS_W-1:0]  r_pos3 [3];
    logic signed [PROD_W-1:0] r_prod [2][3];
    logic signed [PROJ_W-1:0] r_proj [2];
    logic signed [MUL2_W-1:0] r_mul2 [2][3];
    logic signed [RND_W-1:0]  r_rnd  [2][3];
    logic [SQ_W-2:0]          r_sq   [2][3];
    logic [DS_W-1:0]          r_ds   [2];
    t_shell                   r_shell;
    logic signed [FIB_W-1:0]  r_fib;

    logic signed [POS_W-1:0]  w_pos [3];
    t_ctl                     w_ctl;
    t_shell                   n_shell;
    logic signed [FIB_W-1:0]  n_fib;

    assign w_pos[0] = i_pt.pos_x;
    assign w_pos[1] = i_pt.pos_y;
    assign w_pos[2] = i_pt.pos_z;
    assign w_ctl    = '{mode: i_pt.mode, hint: i_pt.hint_fiber, x_neg: i_pt.pos_x[POS_W-1]};

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir[0][0] <= DIR_A_X_RST;
            r_dir[0][1] <= DIR_A_Y_RST;
            r_dir[0][2] <= DIR_A_Z_RST;
            r_dir[1][0] <= DIR_B_X_RST;
            r_dir[1][1] <= DIR_B_Y_RST;
            r_dir[1][2] <= DIR_B_Z_RST;
            r_inner     <= RADIUS_RST;
            r_outer     <= RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIR_A_X: r_dir[0][0] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_A_Y: r_dir[0][1] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_A_Z: r_dir[0][2] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_B_X: r_dir[1][0] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_B_Y: r_dir[1][1] <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_B_Z: r_dir[1][2] <= i_cfg_data[DIR_W-1:0];
                CFG_INNER:   r_inner     <= i_cfg_data[RAD_W-1:0];
                CFG_OUTER:   r_outer     <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // squared radii, sheath raised to the core radius
    always_ff @(posedge i_clk) begin
        r_rm  <= (r_outer < r_inner) ? r_inner : r_outer;
        r_ra2 <= R2_W'(r_inner) * R2_W'(r_inner);
        r_rm2 <= R2_W'(r_rm) * R2_W'(r_rm);
    end

    // a stage loads when it is empty or the next one moves on
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || o_cls.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_pt.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // control travels alongside the data
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_ctl[0] <= w_ctl;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (w_adv[k]) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // stage 1: component products p * d
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_pos1[i] <= w_pos[i];
                for (int f = 0; f < 2; f++) begin
                    r_prod[f][i] <= PROD_W'(w_pos[i]) * PROD_W'(r_dir[f][i]);
                end
            end
        end
    end

    // stage 2: projection onto each fiber axis
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_pos2 <= r_pos1;
            for (int f = 0; f < 2; f++) begin
                r_proj[f] <= PROJ_W'(r_prod[f][0]) + PROJ_W'(r_prod[f][1])
                           + PROJ_W'(r_prod[f][2]);
            end
        end
    end

    // stage 3: proj * d, Q.30
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_pos3 <= r_pos2;
            for (int f = 0; f < 2; f++) begin
                for (int i = 0; i < 3; i++) begin
                    r_mul2[f][i] <= MUL2_W'(r_proj[f]) * MUL2_W'(r_dir[f][i]);
                end
            end
        end
    end

    // stage 4: offset proj*d - p, rounded half up to whole nm
    always_ff @(posedge i_clk) begin
        logic signed [OFF_W-1:0] v_off;
        if (w_adv[3]) begin
            for (int f = 0; f < 2; f++) begin
                for (int i = 0; i < 3; i++) begin
                    v_off = OFF_W'(r_mul2[f][i])
                          - {(OFF_W-RND_SH)'(r_pos3[i]), {RND_SH{1'b0}}}
                          + (OFF_W'(1) <<< (RND_SH - 1));
                    r_rnd[f][i] <= v_off[OFF_W-1:RND_SH];
                end
            end
        end
    end

    // stage 5: squares
    always_ff @(posedge i_clk) begin
        logic signed [SQ_W-1:0] v_sq;
        if (w_adv[4]) begin
            for (int f = 0; f < 2; f++) begin
                for (int i = 0; i < 3; i++) begin
                    v_sq = SQ_W'(r_rnd[f][i]) * SQ_W'(r_rnd[f][i]);
                    r_sq[f][i] <= v_sq[SQ_W-2:0];
                end
            end
        end
    end

    // stage 6: squared distances
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int f = 0; f < 2; f++) begin
                r_ds[f] <= DS_W'(r_sq[f][0]) + DS_W'(r_sq[f][1]) + DS_W'(r_sq[f][2]);
            end
        end
    end

    // stage 7: radius tests and fiber selection
    always_comb begin
        logic core0, core1, sh0, sh1;
        logic signed [FIB_W-1:0] side;
        core0   = r_ds[0] < DS_W'(r_ra2);
        core1   = r_ds[1] < DS_W'(r_ra2);
        sh0     = r_ds[0] < DS_W'(r_rm2);
        sh1     = r_ds[1] < DS_W'(r_rm2);
        side    = r_ctl[NSTG-2].x_neg ? FIB_0 : FIB_1;
        n_shell = SHELL_OUT;
        n_fib   = FIB_NONE;
        if (r_ctl[NSTG-2].mode == MODE_KISS) begin
            // kissing: core on either fiber, then sheath on either
            if (core0 || core1) begin
                n_shell = SHELL_CORE;
                n_fib   = side;
            end else if (sh0 || sh1) begin
                n_shell = SHELL_SHEATH;
                n_fib   = side;
            end
        end else begin
            // crossing: hinted fiber one first, then fibers in order
            if (r_ctl[NSTG-2].hint == FIB_1 && sh1) begin
                n_shell = core1 ? SHELL_CORE : SHELL_SHEATH;
                n_fib   = FIB_1;
            end else if (sh0) begin
                n_shell = core0 ? SHELL_CORE : SHELL_SHEATH;
                n_fib   = FIB_0;
            end else if (sh1) begin
                n_shell = core1 ? SHELL_CORE : SHELL_SHEATH;
                n_fib   = FIB_1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_shell <= n_shell;
            r_fib   <= n_fib;
        end
    end

    // output register
    assign o_cls.valid    = r_vld[NSTG-1];
    assign o_cls.shell    = r_shell;
    assign o_cls.fiber_id = r_fib;

endmodule
`default_nettype wire

/* dv/fspc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_checker
// Watches the config port and both channels of the fiber shell classifier,
// predicts the shell and fiber of every accepted point and compares each
// classification item, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module fspc_checker import fspc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    fspc_in_if                         pt_mon,
    fspc_out_if                        cls_mon,
    output int                         o_err_cnt,
    output int                         o_pending
);

    typedef struct packed {
        t_shell                  shell;
        logic signed [FIB_W-1:0] fiber_id;
    } t_cls;

    // shadow of the block's registers
    logic signed [DIR_W-1:0] dir_a [3];
    logic signed [DIR_W-1:0] dir_b [3];
    logic [RAD_W-1:0]        core_r;
    logic [RAD_W-1:0]        sheath_r;

    t_cls pending_cls_q [$];
    t_cls oldest;

    // squared offset of one axis after rounding to whole nm
    function automatic longint offset_sq(input longint proj, input longint pc,
                                         input longint dc);
        longint e;
        longint r;
        e = proj * dc - (pc <<< RND_SH);
        r = (e + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
        return r * r;
    endfunction

    // squared perpendicular distance of a point from a fiber axis
    function automatic longint fiber_dist_sq(input longint px, input longint py,
                                             input longint pz, input longint dx,
                                             input longint dy, input longint dz);
        longint proj;
        proj = px * dx + py * dy + pz * dz;
        return offset_sq(proj, px, dx) + offset_sq(proj, py, dy) + offset_sq(proj, pz, dz);
    endfunction

    function automatic t_cls classify_point(input logic signed [POS_W-1:0] x,
                                            input logic signed [POS_W-1:0] y,
                                            input logic signed [POS_W-1:0] z,
                                            input logic mode,
                                            input logic signed [FIB_W-1:0] hint);
        t_cls   res;
        longint ds0;
        longint ds1;
        longint ds_h;
        longint core2;
        longint sheath;
        longint sheath2;
        logic   signed [FIB_W-1:0] side;
        bit     found;
        res.shell    = SHELL_OUT;
        res.fiber_id = FIB_NONE;
        found        = 1'b0;
        sheath = (longint'(sheath_r) < longint'(core_r)) ? longint'(core_r)
                                                         : longint'(sheath_r);
        core2   = longint'(core_r) * longint'(core_r);
        sheath2 = sheath * sheath;
        ds0 = fiber_dist_sq(longint'(x), longint'(y), longint'(z),
                            longint'(dir_a[0]), longint'(dir_a[1]), longint'(dir_a[2]));
        ds1 = fiber_dist_sq(longint'(x), longint'(y), longint'(z),
                            longint'(dir_b[0]), longint'(dir_b[1]), longint'(dir_b[2]));
        if (mode != MODE_CROSS) begin
            // kissing: core on either fiber, then sheath; side from sign of x
            side = (x < 0) ? FIB_0 : FIB_1;
            if (ds0 < core2 || ds1 < core2) begin
                res.shell    = SHELL_CORE;
                res.fiber_id = side;
            end else if (ds0 < sheath2 || ds1 < sheath2) begin
                res.shell    = SHELL_SHEATH;
                res.fiber_id = side;
            end
        end else begin
            // crossing: hinted fiber first, a negative hint means none
            if (hint >= 0) begin
                ds_h = (hint == FIB_1) ? ds1 : ds0;
                if (ds_h < core2) begin
                    res.shell = SHELL_CORE;
                    found     = 1'b1;
                end else if (ds_h < sheath2) begin
                    res.shell = SHELL_SHEATH;
                    found     = 1'b1;
                end
                if (found) res.fiber_id = hint;
            end
            if (!found) begin
                if (ds0 < core2) begin
                    res.shell    = SHELL_CORE;
                    res.fiber_id = FIB_0;
                end else if (ds0 < sheath2) begin
                    res.shell    = SHELL_SHEATH;
                    res.fiber_id = FIB_0;
                end else if (ds1 < core2) begin
                    res.shell    = SHELL_CORE;
                    res.fiber_id = FIB_1;
                end else if (ds1 < sheath2) begin
                    res.shell    = SHELL_SHEATH;
                    res.fiber_id = FIB_1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] classify mismatch: %s", $time, what);
        o_err_cnt++;
    endtask

    // track config, predict on every point, check every classification
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_a[0] = DIR_A_X_RST;
            dir_a[1] = DIR_A_Y_RST;
            dir_a[2] = DIR_A_Z_RST;
            dir_b[0] = DIR_B_X_RST;
            dir_b[1] = DIR_B_Y_RST;
            dir_b[2] = DIR_B_Z_RST;
            core_r   = RADIUS_RST;
            sheath_r = RADIUS_RST;
            pending_cls_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIR_A_X: dir_a[0] = i_cfg_data[DIR_W-1:0];
                    CFG_DIR_A_Y: dir_a[1] = i_cfg_data[DIR_W-1:0];
                    CFG_DIR_A_Z: dir_a[2] = i_cfg_data[DIR_W-1:0];
                    CFG_DIR_B_X: dir_b[0] = i_cfg_data[DIR_W-1:0];
                    CFG_DIR_B_Y: dir_b[1] = i_cfg_data[DIR_W-1:0];
                    CFG_DIR_B_Z: dir_b[2] = i_cfg_data[DIR_W-1:0];
                    CFG_INNER:   core_r   = i_cfg_data[RAD_W-1:0];
                    CFG_OUTER:   sheath_r = i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (pt_mon.valid && pt_mon.ready) begin
                pending_cls_q.insert(pending_cls_q.size(),
                                     classify_point(pt_mon.pos_x, pt_mon.pos_y,
                                                    pt_mon.pos_z, pt_mon.mode,
                                                    pt_mon.hint_fiber));
            end
            if (cls_mon.valid && cls_mon.ready) begin
                if (pending_cls_q.size() == 0) begin
                    report_mismatch($sformatf("item with no point pending: shell %0d fiber %0d",
                                              cls_mon.shell, cls_mon.fiber_id));
                end else begin
                    oldest = pending_cls_q.pop_front();
                    if (cls_mon.shell !== oldest.shell)
                        report_mismatch($sformatf("shell %0d, predicted %0d",
                                                  cls_mon.shell, oldest.shell));
                    if (cls_mon.fiber_id !== oldest.fiber_id)
                        report_mismatch($sformatf("fiber_id %0d, predicted %0d",
                                                  cls_mon.fiber_id, oldest.fiber_id));
                end
            end
        end
        o_pending <= pending_cls_q.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams points into the fiber shell classifier under several fiber and
// radius settings, with random idle bursts on both channels (not in the last
// phase); the checker predicts and compares every classification item.
// ----------------------------------------------------------------------------
module tb;
    import fspc_pkg::*;

    localparam realtime CLK_PERIOD = 12ns;
    localparam int      RUN_CYCLES = 200_000;
    localparam int      PHASE_ITEMS = 90;

    // two's complement -2 on the hint field, acts as no hint
    localparam logic signed [FIB_W-1:0] HINT_STALE = -2'sd2;

    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    mode;
        logic signed [FIB_W-1:0] hint;
    } t_point;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rx_ready = 1'b0;
    int                    rx_hold  = 0;
    logic                  bursty;
    int                    err_cnt;
    int                    pending;

    // fiber settings as last written, used to aim points near the fibers
    logic signed [DIR_W-1:0] cur_dir [6];
    logic [RAD_W-1:0]        cur_core;
    logic [RAD_W-1:0]        cur_sheath;

    fspc_in_if  pt_if ();
    fspc_out_if cls_if ();

    assign cls_if.ready = rx_ready;

    fiber_shell_point_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if),
        .o_cls      (cls_if)
    );

    fspc_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .pt_mon     (pt_if),
        .cls_mon    (cls_if),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial begin
        #(RUN_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // classification sink with random stall bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_ready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            rx_ready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (bursty && $urandom_range(0, 5) == 0) begin
            rx_ready <= 1'b0;
            rx_hold  <= $urandom_range(0, 4);
        end else begin
            rx_ready <= 1'b1;
        end
    end

    function automatic t_point mk_point(input int x, input int y, input int z,
                                        input logic mode,
                                        input logic signed [FIB_W-1:0] hint);
        t_point p;
        p.x    = POS_W'(x);
        p.y    = POS_W'(y);
        p.z    = POS_W'(z);
        p.mode = mode;
        p.hint = hint;
        return p;
    endfunction

    // mostly points scattered around one fiber axis, some anywhere
    function automatic t_point random_point();
        t_point p;
        int     fib;
        longint reach;
        longint span;
        longint t;
        longint c [3];
        p.mode = 1'($urandom_range(0, 1));
        p.hint = FIB_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 3) begin
            p.x = POS_W'($urandom);
            p.y = POS_W'($urandom);
            p.z = POS_W'($urandom);
        end else begin
            fib   = $urandom_range(0, 1);
            reach = (cur_sheath > cur_core) ? longint'(cur_sheath) : longint'(cur_core);
            span  = reach * 3 / 4 + 8;
            t     = longint'($urandom_range(0, 16777215)) - 8388608;
            for (int i = 0; i < 3; i++) begin
                c[i] = ((t * cur_dir[fib * 3 + i]) >>> FRAC_W)
                     + longint'($urandom_range(0, int'(2 * span))) - span;
                if (c[i] > POS_MAX) c[i] = POS_MAX;
                if (c[i] < POS_MIN) c[i] = POS_MIN;
            end
            p.x = POS_W'(c[0]);
            p.y = POS_W'(c[1]);
            p.z = POS_W'(c[2]);
        end
        return p;
    endfunction

    task automatic send_point(input t_point p);
        pt_if.valid      <= 1'b1;
        pt_if.pos_x      <= p.x;
        pt_if.pos_y      <= p.y;
        pt_if.pos_z      <= p.z;
        pt_if.mode       <= p.mode;
        pt_if.hint_fiber <= p.hint;
        @(posedge clk);
        while (!pt_if.ready) @(posedge clk);
        if (bursty && $urandom_range(0, 3) == 0) begin
            pt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // write every register; directions go out sign extended
    task automatic load_settings(input logic signed [DIR_W-1:0] ax,
                                 input logic signed [DIR_W-1:0] ay,
                                 input logic signed [DIR_W-1:0] az,
                                 input logic signed [DIR_W-1:0] bx,
                                 input logic signed [DIR_W-1:0] by,
                                 input logic signed [DIR_W-1:0] bz,
                                 input logic [RAD_W-1:0] r_core,
                                 input logic [RAD_W-1:0] r_sheath);
        write_reg(CFG_DIR_A_X, CFG_DATA_W'(ax));
        write_reg(CFG_DIR_A_Y, CFG_DATA_W'(ay));
        write_reg(CFG_DIR_A_Z, CFG_DATA_W'(az));
        write_reg(CFG_DIR_B_X, CFG_DATA_W'(bx));
        write_reg(CFG_DIR_B_Y, CFG_DATA_W'(by));
        write_reg(CFG_DIR_B_Z, CFG_DATA_W'(bz));
        write_reg(CFG_INNER, r_core);
        write_reg(CFG_OUTER, r_sheath);
        cfg_we     <= 1'b0;
        cur_dir[0] = ax;
        cur_dir[1] = ay;
        cur_dir[2] = az;
        cur_dir[3] = bx;
        cur_dir[4] = by;
        cur_dir[5] = bz;
        cur_core   = r_core;
        cur_sheath = r_sheath;
    endtask

    // random points, with a quiet stretch in the middle when bursts are on
    task automatic run_random(input int n, input bit allow_idle);
        for (int k = 0; k < n; k++) begin
            bursty <= allow_idle && !(k >= 40 && k < 60);
            send_point(random_point());
        end
        wait_drained();
    endtask

    // stimulus and verdict
    initial begin
        pt_if.valid      <= 1'b0;
        pt_if.pos_x      <= '0;
        pt_if.pos_y      <= '0;
        pt_if.pos_z      <= '0;
        pt_if.mode       <= MODE_KISS;
        pt_if.hint_fiber <= FIB_NONE;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_DIR_A_X;
        cfg_data         <= '0;
        bursty           <= 1'b1;
        rst_n            <= 1'b0;
        cur_dir[0] = DIR_A_X_RST;
        cur_dir[1] = DIR_A_Y_RST;
        cur_dir[2] = DIR_A_Z_RST;
        cur_dir[3] = DIR_B_X_RST;
        cur_dir[4] = DIR_B_Y_RST;
        cur_dir[5] = DIR_B_Z_RST;
        cur_core   = RADIUS_RST;
        cur_sheath = RADIUS_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, core edge on the z axis, hints
        send_point(mk_point(0, 0, 0, MODE_KISS, FIB_0));
        send_point(mk_point(POS_MAX, POS_MAX, POS_MAX, MODE_KISS, FIB_1));
        send_point(mk_point(POS_MIN, POS_MIN, POS_MIN, MODE_CROSS, FIB_NONE));
        send_point(mk_point(POS_MAX, POS_MIN, 0, MODE_CROSS, FIB_1));
        send_point(mk_point(0, 0, 1999999, MODE_KISS, FIB_NONE));
        send_point(mk_point(0, 0, 2000000, MODE_KISS, FIB_NONE));
        send_point(mk_point(-1, 0, 1999000, MODE_KISS, FIB_1));
        send_point(mk_point(0, 0, -1999999, MODE_CROSS, HINT_STALE));
        send_point(mk_point(0, 0, 100, MODE_CROSS, FIB_1));
        send_point(mk_point(0, 0, 100, MODE_CROSS, FIB_0));
        send_point(mk_point(0, 0, 100, MODE_CROSS, FIB_NONE));
        send_point(mk_point(4000000, 4000000, 0, MODE_CROSS, FIB_1));
        send_point(mk_point(4000000, -4000000, 0, MODE_CROSS, FIB_0));
        send_point(mk_point(4000000, -4000000, 0, MODE_KISS, FIB_1));
        send_point(mk_point(-4000000, 4000000, 0, MODE_KISS, FIB_0));
        send_point(mk_point(POS_MIN, 0, 0, MODE_KISS, HINT_STALE));
        send_point(mk_point(0, POS_MAX, POS_MIN, MODE_CROSS, FIB_0));
        run_random(PHASE_ITEMS, 1'b1);

        // axis fibers with a sheath wider than the core
        load_settings(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0,
                      23'd1000000, 23'd3000000);
        send_point(mk_point(0, 0, 1500000, MODE_CROSS, FIB_1));
        send_point(mk_point(0, 0, 1500000, MODE_KISS, FIB_NONE));
        send_point(mk_point(0, 0, 999999, MODE_CROSS, FIB_NONE));
        send_point(mk_point(0, 0, 3500000, MODE_CROSS, FIB_0));
        run_random(PHASE_ITEMS, 1'b1);

        // most negative and most positive directions, sheath below core
        load_settings(-16'sd32768, -16'sd32768, -16'sd32768,
                      16'sd32767, 16'sd32767, 16'sd32767, 23'h7FFFFF, 23'd0);
        run_random(PHASE_ITEMS, 1'b1);

        // zero first direction, no core at all, widest sheath
        load_settings(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768,
                      23'd0, 23'h7FFFFF);
        run_random(PHASE_ITEMS, 1'b1);

        // arbitrary directions and radii
        load_settings(DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom),
                      DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom),
                      RAD_W'($urandom_range(0, 4000000)), RAD_W'($urandom_range(0, 6000000)));
        run_random(PHASE_ITEMS, 1'b1);

        // diagonal fibers at full rate
        load_settings(16'sd0, 16'sd23170, 16'sd23170, 16'sd23170, 16'sd0, -16'sd23170,
                      23'd1500000, 23'd2500000);
        run_random(PHASE_ITEMS, 1'b0);

        repeat (NSTG + 4) @(posedge clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (pending != 0) $display("%0d classifications never arrived", pending);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fspc_pkg.sv
hw/rtl/fspc_in_if.sv
hw/rtl/fspc_out_if.sv
hw/rtl/fiber_shell_point_classifier.sv
dv/fspc_checker.sv
dv/tb.sv
